FILE: rtl/core/iee_pkg.sv
// Shared constants, widths and a helper function of the infix expression evaluator.
// No dependencies; used by the top level and the checker by scoped names.
package iee_pkg;

  localparam int unsigned VALUE_DEPTH    = 16;
  localparam int unsigned OPERATOR_DEPTH = 16;
  localparam int unsigned DATA_W         = 32;

  localparam int unsigned VCNT_W  = $clog2(VALUE_DEPTH + 1);
  localparam int unsigned VADDR_W = $clog2(VALUE_DEPTH);
  localparam int unsigned OCNT_W  = $clog2(OPERATOR_DEPTH + 1);
  localparam int unsigned OADDR_W = $clog2(OPERATOR_DEPTH);

  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_DIGIT = 2'd0;
  localparam logic [1:0] OP_OPER  = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;

  localparam logic [1:0] OPC_ADD = 2'd0;
  localparam logic [1:0] OPC_SUB = 2'd1;
  localparam logic [1:0] OPC_MUL = 2'd2;
  localparam logic [1:0] OPC_DIV = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  function automatic logic prec_high(input logic [1:0] code);
    return (code == OPC_MUL) || (code == OPC_DIV);
  endfunction

endpackage

FILE: rtl/core/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: token sequencer, stacks and ALU.
// Depends on iee_pkg and iee_ram.

// Tokens arrive as valid/ready transactions. A digit is pushed in S_IDLE and
// in_ready_o stays high. An operator passes through S_CHECK, and S_RD for each
// stacked operator it applies, plus S_DIV and S_DIVFIN for each applied divide
// (a radix-2 divider retires one quotient bit per cycle). An evaluate does the
// same plus S_EMIT, which loads the output register and waits while the
// previous result is still held there. The output register holds the result
// until taken while new tokens are accepted. With an error latched, a digit or
// operator is dropped and an evaluate passes only through S_CHECK and S_EMIT.
// Each applied operator costs one read of the value stack memory and the
// operator stack memory; the top entries of both stacks are kept in registers.
// After an evaluate the stacks and the error state are empty again.
module infix_expression_evaluator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  digit_value_i,
  input  logic [1:0]  operator_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]  error_code_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DIVFIN = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  localparam int unsigned VCNT_W  = iee_pkg::VCNT_W;
  localparam int unsigned VADDR_W = iee_pkg::VADDR_W;
  localparam int unsigned OCNT_W  = iee_pkg::OCNT_W;
  localparam int unsigned OADDR_W = iee_pkg::OADDR_W;
  localparam int unsigned DATA_W  = iee_pkg::DATA_W;
  localparam int unsigned DCNT_W  = iee_pkg::DCNT_W;

  logic [2:0]        state_q, state_d;
  logic [VCNT_W-1:0] vcnt_q, vcnt_d;
  logic [OCNT_W-1:0] ocnt_q, ocnt_d;
  logic [1:0]        err_q, err_d;
  logic              eval_q, eval_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic              out_valid_q, out_valid_d;

  logic [DATA_W-1:0] tv_q, tv_d;
  logic [1:0]        to_q, to_d;
  logic [1:0]        pend_q, pend_d;
  logic [DATA_W-1:0] dvd_q, dvd_d;
  logic [DATA_W-1:0] dvs_q, dvs_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic              neg_q, neg_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [1:0]        ecode_q, ecode_d;

  logic               v_we, v_re, o_we, o_re;
  logic [VADDR_W-1:0] v_waddr, v_raddr;
  logic [OADDR_W-1:0] o_waddr, o_raddr;
  logic [DATA_W-1:0]  v_wdata, v_rdata;
  logic [1:0]         o_wdata, o_rdata;

  logic [VCNT_W-1:0]  vcnt_m1, vcnt_m2;
  logic [OCNT_W-1:0]  ocnt_m1, ocnt_m2;
  logic               accept;
  logic               do_apply;
  logic [DATA_W:0]    rem_sh, trial;
  logic               ge;
  logic [DATA_W-1:0]  op_a, op_b, mag_a, mag_b;

  iee_ram #(.WIDTH(DATA_W), .DEPTH(iee_pkg::VALUE_DEPTH)) u_vram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  iee_ram #(.WIDTH(2), .DEPTH(iee_pkg::OPERATOR_DEPTH)) u_oram (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (o_waddr),
    .wdata_i (o_wdata),
    .re_i    (o_re),
    .raddr_i (o_raddr),
    .rdata_o (o_rdata)
  );

  assign vcnt_m1 = vcnt_q - VCNT_W'(1);
  assign vcnt_m2 = vcnt_q - VCNT_W'(2);
  assign ocnt_m1 = ocnt_q - OCNT_W'(1);
  assign ocnt_m2 = ocnt_q - OCNT_W'(2);

  assign v_waddr = vcnt_m1[VADDR_W-1:0];
  assign v_raddr = vcnt_m2[VADDR_W-1:0];
  assign v_wdata = tv_q;
  assign o_waddr = ocnt_m1[OADDR_W-1:0];
  assign o_raddr = ocnt_m2[OADDR_W-1:0];
  assign o_wdata = to_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign do_apply = (ocnt_q != '0) &&
                    (eval_q || iee_pkg::prec_high(to_q) || !iee_pkg::prec_high(pend_q));

  assign op_a  = v_rdata;
  assign op_b  = tv_q;
  assign mag_a = op_a[DATA_W-1] ? (DATA_W'(0) - op_a) : op_a;
  assign mag_b = op_b[DATA_W-1] ? (DATA_W'(0) - op_b) : op_b;

  assign rem_sh = {rem_q, dvd_q[DATA_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_q};
  assign ge     = !trial[DATA_W];

  always_comb begin
    state_d     = state_q;
    vcnt_d      = vcnt_q;
    ocnt_d      = ocnt_q;
    err_d       = err_q;
    eval_d      = eval_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    tv_d        = tv_q;
    to_d        = to_q;
    pend_d      = pend_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    res_d       = res_q;
    ecode_d     = ecode_q;
    v_we        = 1'b0;
    v_re        = 1'b0;
    o_we        = 1'b0;
    o_re        = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            iee_pkg::OP_DIGIT: begin
              if (err_q == iee_pkg::ERR_NONE) begin
                if (vcnt_q == VCNT_W'(iee_pkg::VALUE_DEPTH)) begin
                  err_d = iee_pkg::ERR_OVERFLOW;
                end else begin
                  v_we   = (vcnt_q != '0);
                  tv_d   = DATA_W'(digit_value_i);
                  vcnt_d = vcnt_q + VCNT_W'(1);
                end
              end
            end
            iee_pkg::OP_OPER: begin
              if (err_q == iee_pkg::ERR_NONE) begin
                pend_d  = operator_code_i;
                eval_d  = 1'b0;
                state_d = S_CHECK;
              end
            end
            iee_pkg::OP_EVAL: begin
              eval_d  = 1'b1;
              state_d = S_CHECK;
            end
            default: begin
            end
          endcase
        end
      end

      S_CHECK: begin
        if (err_q != iee_pkg::ERR_NONE) begin
          state_d = eval_q ? S_EMIT : S_IDLE;
        end else if (do_apply) begin
          if (vcnt_q < VCNT_W'(2)) begin
            err_d  = iee_pkg::ERR_UNDERFLOW;
            ocnt_d = ocnt_m1;
          end else begin
            v_re    = 1'b1;
            o_re    = 1'b1;
            state_d = S_RD;
          end
        end else if (eval_q) begin
          state_d = S_EMIT;
        end else begin
          if (ocnt_q == OCNT_W'(iee_pkg::OPERATOR_DEPTH)) begin
            err_d = iee_pkg::ERR_OVERFLOW;
          end else begin
            o_we   = (ocnt_q != '0);
            to_d   = pend_q;
            ocnt_d = ocnt_q + OCNT_W'(1);
          end
          state_d = S_IDLE;
        end
      end

      S_RD: begin
        ocnt_d  = ocnt_m1;
        to_d    = o_rdata;
        state_d = S_CHECK;
        case (to_q)
          iee_pkg::OPC_ADD: begin
            tv_d   = op_a + op_b;
            vcnt_d = vcnt_m1;
          end
          iee_pkg::OPC_SUB: begin
            tv_d   = op_a - op_b;
            vcnt_d = vcnt_m1;
          end
          iee_pkg::OPC_MUL: begin
            tv_d   = op_a * op_b;
            vcnt_d = vcnt_m1;
          end
          default: begin
            if (op_b == '0) begin
              err_d = iee_pkg::ERR_DIV_ZERO;
            end else begin
              dvd_d   = mag_a;
              dvs_d   = mag_b;
              rem_d   = '0;
              neg_d   = op_a[DATA_W-1] ^ op_b[DATA_W-1];
              dcnt_d  = '0;
              state_d = S_DIV;
            end
          end
        endcase
      end

      S_DIV: begin
        rem_d  = ge ? trial[DATA_W-1:0] : rem_sh[DATA_W-1:0];
        dvd_d  = {dvd_q[DATA_W-2:0], ge};
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(iee_pkg::DIV_STEPS - 1)) begin
          state_d = S_DIVFIN;
        end
      end

      S_DIVFIN: begin
        tv_d    = neg_q ? (DATA_W'(0) - dvd_q) : dvd_q;
        vcnt_d  = vcnt_m1;
        state_d = S_CHECK;
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (err_q != iee_pkg::ERR_NONE) begin
            res_d   = '0;
            ecode_d = err_q;
          end else if (vcnt_q == '0) begin
            res_d   = '0;
            ecode_d = iee_pkg::ERR_UNDERFLOW;
          end else begin
            res_d   = tv_q;
            ecode_d = iee_pkg::ERR_NONE;
          end
          vcnt_d  = '0;
          ocnt_d  = '0;
          err_d   = iee_pkg::ERR_NONE;
          eval_d  = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcnt_q      <= '0;
      ocnt_q      <= '0;
      err_q       <= iee_pkg::ERR_NONE;
      eval_q      <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcnt_q      <= vcnt_d;
      ocnt_q      <= ocnt_d;
      err_q       <= err_d;
      eval_q      <= eval_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tv_q    <= tv_d;
    to_q    <= to_d;
    pend_q  <= pend_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    res_q   <= res_d;
    ecode_q <= ecode_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign error_code_o   = ecode_q;

endmodule

FILE: rtl/core/iee_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module iee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/iee_checker.sv
// Port-level assertions for the infix expression evaluator, bound to the top level.
// Depends on iee_pkg and infix_expression_evaluator.
module iee_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  op_i,
  input logic [3:0]  digit_value_i,
  input logic [1:0]  operator_code_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic signed [31:0] result_value_o,
  input logic [1:0]  error_code_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(result_value_o) && $stable(error_code_o))
    else $error("result transaction changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != iee_pkg::ERR_NONE) |-> result_value_o == 0)
    else $error("nonzero result with an error code");

  a_digit_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i == iee_pkg::OP_DIGIT) |=> !$rose(out_valid_o))
    else $error("result emitted right after a digit transaction");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_i == iee_pkg::OP_EVAL) |=> !in_ready_o)
    else $error("ready right after an evaluate transaction");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (.*);
